>>> src/nmpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, register and mode codes, and the quarter-wave sine generator.
package nmpd_pkg;

   localparam int DECIM_W = 5;

   localparam logic [2:0] CSR_DECIM  = 3'd0;
   localparam logic [2:0] CSR_MODE   = 3'd1;
   localparam logic [2:0] CSR_STEP   = 3'd2;
   localparam logic [2:0] CSR_CHIRP  = 3'd3;
   localparam logic [2:0] CSR_BRANCH = 3'd4;

   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_NCO   = 2'd1;
   localparam logic [1:0] MODE_CHIRP = 2'd2;
   localparam logic [1:0] MODE_ROT   = 2'd3;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TAP    = 1'b1;

   localparam logic [DECIM_W-1:0] DECIM_RESET = 5'd2;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef struct packed {
      logic [DECIM_W-1:0] decim_factor;
      logic [1:0]         mode;
      logic [31:0]        nco_step;
      logic [31:0]        nco_chirp;
      logic [31:0]        branch_phase_step;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic [8:0]         tap_index;
      logic signed [17:0] tap_value;
   } cmd_type;

   // Q1.15 sine of n*pi/2^(b-1) by a truncating Horner series in Q30.
   function automatic logic signed [15:0] quarter_sine(input int unsigned n,
                                                       input int unsigned b);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (64'(n) * PI_Q30) >> (b - 1);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return signed'(s[15:0]);
   endfunction

endpackage

>>> src/nmpd_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and register writes.
interface nmpd_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] sample_re;
   logic signed [15:0] sample_im;
   logic [8:0]         tap_index;
   logic signed [17:0] tap_value;
   modport source (output valid, func, sample_re, sample_im, tap_index, tap_value,
                   input ready);
   modport sink (input valid, func, sample_re, sample_im, tap_index, tap_value,
                 output ready);
endinterface

interface nmpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] out_re;
   logic signed [47:0] out_im;
   modport source (output valid, out_re, out_im, input ready);
   modport sink (input valid, out_re, out_im, output ready);
endinterface

interface nmpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/nmpd_sincos.sv
`timescale 1ns / 1ps
// Folded quarter-wave sine and cosine lookup with registered outputs.
module nmpd_sincos import nmpd_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic [31:0]        phase,
   output logic signed [15:0] sin_ff,
   output logic signed [15:0] cos_ff
);
   localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
   localparam int QW = SINE_TABLE_BITS - 1;
   localparam int RW = SINE_TABLE_BITS - 2;

   logic signed [15:0]         qtab [QUARTER + 1];
   logic [SINE_TABLE_BITS-1:0] idx_s;
   logic [SINE_TABLE_BITS-1:0] idx_c;
   logic [QW-1:0]              qi_s;
   logic [QW-1:0]              qi_c;
   logic signed [15:0]         sin_in;
   logic signed [15:0]         cos_in;

   for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
      assign qtab[i] = quarter_sine(i, SINE_TABLE_BITS);
   end

   always_comb begin
      idx_s  = phase[31 -: SINE_TABLE_BITS];
      idx_c  = idx_s + SINE_TABLE_BITS'(QUARTER);
      qi_s   = idx_s[RW] ? QW'(QUARTER) - QW'(idx_s[RW-1:0]) : QW'(idx_s[RW-1:0]);
      qi_c   = idx_c[RW] ? QW'(QUARTER) - QW'(idx_c[RW-1:0]) : QW'(idx_c[RW-1:0]);
      sin_in = idx_s[SINE_TABLE_BITS-1] ? -qtab[qi_s] : qtab[qi_s];
      cos_in = idx_c[SINE_TABLE_BITS-1] ? -qtab[qi_c] : qtab[qi_c];
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

endmodule

>>> src/nmpd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the request front end and the filter engine.
module nmpd_queue import nmpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);
   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] wr_in;
   logic [PW-1:0] rd_ff;
   logic [PW-1:0] rd_in;
   logic [PW:0]   count_ff;
   logic [PW:0]   count_in;
   logic          do_push;
   logic          do_pop;

   always_comb begin
      full     = (count_ff == (PW + 1)'(QUEUE_DEPTH));
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = slot_ff[rd_ff];
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> src/nmpd_front.sv
`timescale 1ns / 1ps
// Request front end: takes requests, runs the oscillator and mixer, queues commands.
module nmpd_front import nmpd_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   nmpd_req_if.sink req_bus,
   output logic    push,
   output cmd_type push_data,
   input  logic    full
);
   typedef enum logic [5:0] {
      F_IDLE  = 6'b000001,
      F_CHIRP = 6'b000010,
      F_PHASE = 6'b000100,
      F_LOOK  = 6'b001000,
      F_MULT  = 6'b010000,
      F_PUSH  = 6'b100000
   } front_state_type;

   front_state_type    state_ff;
   front_state_type    state_in;
   cmd_type            cmd_ff;
   cmd_type            cmd_in;
   logic               mix_ff;
   logic               mix_in;
   logic [31:0]        phase_ff;
   logic [31:0]        phase_in;
   logic [31:0]        chirp_ff;
   logic [31:0]        chirp_in;
   logic signed [15:0] sin_val;
   logic signed [15:0] cos_val;
   logic signed [31:0] prod_rc_ff;
   logic signed [31:0] prod_is_ff;
   logic signed [31:0] prod_rs_ff;
   logic signed [31:0] prod_ic_ff;
   logic signed [32:0] mix_re;
   logic signed [32:0] mix_im;

   function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
      logic signed [33:0] r;
      logic signed [18:0] q;
      r = 34'(v) + 34'sd16384;
      q = 19'(r >>> 15);
      if (q > 19'sd32767) begin
         return 16'sh7fff;
      end else if (q < -19'sd32768) begin
         return 16'sh8000;
      end
      return 16'(q);
   endfunction

   nmpd_sincos #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_sincos (
      .clock (clock),
      .phase (phase_ff),
      .sin_ff(sin_val),
      .cos_ff(cos_val)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      mix_in        = mix_ff;
      phase_in      = phase_ff;
      chirp_in      = chirp_ff;
      req_bus.ready = (state_ff == F_IDLE);
      push          = 1'b0;
      mix_re        = 33'(prod_rc_ff) - 33'(prod_is_ff);
      mix_im        = 33'(prod_rs_ff) + 33'(prod_ic_ff);
      push_data     = cmd_ff;
      if (mix_ff) begin
         push_data.sample_re = round_sat(mix_re);
         push_data.sample_im = round_sat(mix_im);
      end
      unique case (state_ff)
         F_IDLE: begin
            if (req_bus.valid) begin
               cmd_in.func      = req_bus.func;
               cmd_in.sample_re = req_bus.sample_re;
               cmd_in.sample_im = req_bus.sample_im;
               cmd_in.tap_index = req_bus.tap_index;
               cmd_in.tap_value = req_bus.tap_value;
               mix_in = (req_bus.func == FUNC_SAMPLE) &&
                        (cfg.mode == MODE_NCO || cfg.mode == MODE_CHIRP);
               state_in = mix_in ? F_CHIRP : F_PUSH;
            end
         end
         F_CHIRP: begin
            if (cfg.mode == MODE_CHIRP) begin
               chirp_in = chirp_ff + cfg.nco_chirp;
            end
            state_in = F_PHASE;
         end
         F_PHASE: begin
            phase_in = phase_ff + cfg.nco_step +
                       ((cfg.mode == MODE_CHIRP) ? chirp_ff : 32'd0);
            state_in = F_LOOK;
         end
         F_LOOK: begin
            state_in = F_MULT;
         end
         F_MULT: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push = !full;
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         mix_ff   <= 1'b0;
         phase_ff <= '0;
         chirp_ff <= '0;
      end else begin
         state_ff <= state_in;
         mix_ff   <= mix_in;
         phase_ff <= phase_in;
         chirp_ff <= chirp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (state_ff == F_MULT) begin
         prod_rc_ff <= cmd_ff.sample_re * cos_val;
         prod_is_ff <= cmd_ff.sample_im * sin_val;
         prod_rs_ff <= cmd_ff.sample_re * sin_val;
         prod_ic_ff <= cmd_ff.sample_im * cos_val;
      end
   end

endmodule

>>> src/nmpd_back.sv
`timescale 1ns / 1ps
// Filter engine: sample history, tap memory and the shared complex multiply-accumulate.
module nmpd_back import nmpd_pkg::*; #(
   parameter int TAPS_PER_BRANCH = 20,
   parameter int MAX_DECIM = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    empty,
   input  cmd_type pop_data,
   output logic    pop,
   nmpd_rsp_if.source rsp_bus
);
   localparam int DEPTH = TAPS_PER_BRANCH * MAX_DECIM;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int MW = $clog2(MAX_DECIM + 1);

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_RUN   = 4'b0010,
      B_DRAIN = 4'b0100,
      B_DONE  = 4'b1000
   } back_state_type;

   back_state_type     state_ff;
   back_state_type     state_in;
   logic [AW-1:0]      wpos_ff;
   logic [AW-1:0]      wpos_in;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      fill_in;
   logic [MW-1:0]      bcnt_ff;
   logic [MW-1:0]      bcnt_in;
   logic [AW-1:0]      n_ff;
   logic [AW-1:0]      n_in;
   logic [AW-1:0]      last_ff;
   logic [AW-1:0]      last_in;
   logic [AW-1:0]      pos_ff;
   logic [AW-1:0]      pos_in;
   logic [MW-1:0]      j_ff;
   logic [MW-1:0]      j_in;
   logic [MW-1:0]      m_run_ff;
   logic [MW-1:0]      m_run_in;
   logic [31:0]        rot_ff;
   logic [31:0]        rot_in;
   logic [2:0]         pv_ff;
   logic [2:0]         pv_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [47:0] rsp_re_ff;
   logic signed [47:0] rsp_im_ff;
   logic signed [47:0] acc_re_ff;
   logic signed [47:0] acc_im_ff;
   logic [MW-1:0]      m_eff;
   logic               hist_we;
   logic               tap_we;
   logic [AW-1:0]      tap_addr;
   logic               acc_clr;
   logic               rsp_load;

   logic [31:0]        hist_mem [DEPTH];
   logic signed [17:0] tap_mem [DEPTH];

   logic signed [17:0] h_a_ff;
   logic [31:0]        x_a_ff;
   logic               xv_a_ff;
   logic signed [15:0] sin_val;
   logic signed [15:0] cos_val;
   logic signed [17:0] h_b_ff;
   logic signed [15:0] xr_b_ff;
   logic signed [15:0] xi_b_ff;
   logic signed [33:0] hc_b_ff;
   logic signed [33:0] hs_b_ff;
   logic signed [34:0] hc_rnd;
   logic signed [34:0] hs_rnd;
   logic signed [18:0] hr;
   logic signed [18:0] hi;
   logic signed [34:0] p1_ff;
   logic signed [34:0] p2_ff;
   logic signed [34:0] p3_ff;
   logic signed [34:0] p4_ff;

   nmpd_sincos #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_sincos (
      .clock (clock),
      .phase (rot_ff),
      .sin_ff(sin_val),
      .cos_ff(cos_val)
   );

   always_comb begin
      if (cfg.decim_factor == '0) begin
         m_eff = MW'(1);
      end else if (32'(cfg.decim_factor) > MAX_DECIM) begin
         m_eff = MW'(MAX_DECIM);
      end else begin
         m_eff = MW'(cfg.decim_factor);
      end
   end

   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      bcnt_in      = bcnt_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      m_run_in     = m_run_ff;
      rot_in       = rot_ff;
      pv_in        = {pv_ff[1:0], 1'b0};
      pop          = 1'b0;
      hist_we      = 1'b0;
      tap_we       = 1'b0;
      tap_addr     = AW'(pop_data.tap_index);
      acc_clr      = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (pop_data.func == FUNC_TAP) begin
                  tap_we = (32'(pop_data.tap_index) < DEPTH);
               end else begin
                  hist_we = 1'b1;
                  wpos_in = (32'(wpos_ff) == DEPTH - 1) ? '0 : wpos_ff + 1'b1;
                  if (32'(fill_ff) < DEPTH) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (32'(bcnt_ff) + 1 >= 32'(m_eff)) begin
                     bcnt_in  = '0;
                     pos_in   = wpos_ff;
                     n_in     = '0;
                     j_in     = '0;
                     rot_in   = '0;
                     m_run_in = m_eff;
                     last_in  = AW'(TAPS_PER_BRANCH * int'(m_eff) - 1);
                     acc_clr  = 1'b1;
                     state_in = B_RUN;
                  end else begin
                     bcnt_in = bcnt_ff + 1'b1;
                  end
               end
            end
         end
         B_RUN: begin
            pv_in[0] = 1'b1;
            n_in     = n_ff + 1'b1;
            pos_in   = (pos_ff == '0) ? AW'(DEPTH - 1) : pos_ff - 1'b1;
            if (32'(j_ff) + 1 >= 32'(m_run_ff)) begin
               j_in   = '0;
               rot_in = '0;
            end else begin
               j_in   = j_ff + 1'b1;
               rot_in = rot_ff + cfg.branch_phase_step;
            end
            if (n_ff == last_ff) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (pv_ff == '0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      hc_rnd = 35'(hc_b_ff) + 35'sd16384;
      hs_rnd = 35'(hs_b_ff) + 35'sd16384;
      if (cfg.mode == MODE_ROT) begin
         hr = 19'(hc_rnd >>> 15);
         hi = 19'(hs_rnd >>> 15);
      end else begin
         hr = 19'(h_b_ff);
         hi = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         bcnt_ff      <= '0;
         n_ff         <= '0;
         last_ff      <= '0;
         pos_ff       <= '0;
         j_ff         <= '0;
         m_run_ff     <= MW'(1);
         rot_ff       <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         bcnt_ff      <= bcnt_in;
         n_ff         <= n_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         j_ff         <= j_in;
         m_run_ff     <= m_run_in;
         rot_ff       <= rot_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wpos_ff] <= {pop_data.sample_re, pop_data.sample_im};
      end
      x_a_ff  <= hist_mem[pos_ff];
      xv_a_ff <= (FW'(pos_ff) < fill_ff);
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[tap_addr] <= pop_data.tap_value;
      end
      h_a_ff <= tap_mem[n_ff];
   end

   always_ff @(posedge clock) begin
      h_b_ff  <= h_a_ff;
      xr_b_ff <= xv_a_ff ? signed'(x_a_ff[31:16]) : '0;
      xi_b_ff <= xv_a_ff ? signed'(x_a_ff[15:0]) : '0;
      hc_b_ff <= h_a_ff * cos_val;
      hs_b_ff <= h_a_ff * sin_val;
      p1_ff   <= hr * xr_b_ff;
      p2_ff   <= hi * xi_b_ff;
      p3_ff   <= hr * xi_b_ff;
      p4_ff   <= hi * xr_b_ff;
      if (acc_clr) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (pv_ff[2]) begin
         acc_re_ff <= acc_re_ff + 48'(p1_ff) - 48'(p2_ff);
         acc_im_ff <= acc_im_ff + 48'(p3_ff) + 48'(p4_ff);
      end
      if (rsp_load) begin
         rsp_re_ff <= acc_re_ff;
         rsp_im_ff <= acc_im_ff;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.out_re = rsp_re_ff;
   assign rsp_bus.out_im = rsp_im_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= DEPTH)
      else $error("History fill count exceeds the history depth.");

   a_pipe_state: assert property (@(posedge clock) disable iff (reset)
      (pv_ff != '0) |-> (state_ff == B_RUN || state_ff == B_DRAIN))
      else $error("Accumulator pipeline busy outside a filter run.");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (n_ff <= last_ff))
      else $error("Tap counter ran past the last tap.");

   a_branch_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bcnt_ff) < MAX_DECIM)
      else $error("Branch counter outside the decimation range.");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == B_IDLE))
      else $error("Finished sum was not moved to the result register.");

endmodule

>>> src/nco_mix_polyphase_decimator.sv
`timescale 1ns / 1ps
// Top level of the NCO mixer and polyphase decimating filter with its register file.
// A request is either a tap write or a complex sample. The front end takes a new request only
// after it has pushed the last one: a request that passes straight through goes directly to
// the push step, and one mixed with the oscillator first steps through the chirp, phase,
// lookup and multiply states; requests then wait in a four-entry queue for the filter engine.
// The engine stores each sample and, on every M-th sample, runs one complex
// multiply-accumulate unit over TAPS_PER_BRANCH*M taps, one tap per cycle, then drains
// its pipeline. Unwritten history reads as zero through a fill count, so the block needs
// no clearing pass after reset. The result sits in an output register, so the engine keeps
// taking samples while a result waits, but holds its next sum until that result is taken.
module nco_mix_polyphase_decimator import nmpd_pkg::*; #(
   parameter int TAPS_PER_BRANCH = 20,
   parameter int MAX_DECIM = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input logic clock,
   input logic reset,
   nmpd_req_if.sink   req_bus,
   nmpd_rsp_if.source rsp_bus,
   nmpd_csr_if.sink   csr_bus
);
   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    push;
   cmd_type push_data;
   logic    full;
   logic    pop;
   logic    empty;
   cmd_type pop_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DECIM:  cfg_in.decim_factor      = csr_bus.data[DECIM_W-1:0];
            CSR_MODE:   cfg_in.mode              = csr_bus.data[1:0];
            CSR_STEP:   cfg_in.nco_step          = csr_bus.data;
            CSR_CHIRP:  cfg_in.nco_chirp         = csr_bus.data;
            CSR_BRANCH: cfg_in.branch_phase_step = csr_bus.data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decim_factor      <= DECIM_RESET;
         cfg_ff.mode              <= MODE_PASS;
         cfg_ff.nco_step          <= '0;
         cfg_ff.nco_chirp         <= '0;
         cfg_ff.branch_phase_step <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nmpd_front #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_bus  (req_bus),
      .push     (push),
      .push_data(push_data),
      .full     (full)
   );

   nmpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_data (pop_data)
   );

   nmpd_back #(
      .TAPS_PER_BRANCH(TAPS_PER_BRANCH),
      .MAX_DECIM      (MAX_DECIM),
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .empty   (empty),
      .pop_data(pop_data),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
